[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mlqs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mlqs: next-cycle check failed");

`endif

[rtl/mlqs_pkg.sv]
// Shared constants, types and helpers for the multilevel queue scheduler.
package mlqs_pkg;

	localparam int NUM_CLASSES    = 8;
	localparam int CLASS_DEPTH    = 16;
	localparam int PRIO_PER_CLASS = 4;

	localparam int FUNC_W = 2;
	localparam int ID_W   = 16;
	localparam int PRIO_W = 5;
	localparam int CPU_W  = 8;
	localparam int STAT_W = 3;

	localparam int ENTRY_W   = ID_W + PRIO_W + CPU_W;
	localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int PTR_W     = $clog2(CLASS_DEPTH);
	localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
	localparam int ADDR_W    = CLS_W + PTR_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ENQ   = 2'd0,
		FUNC_DISP  = 2'd1,
		FUNC_DECAY = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ENQ   = 3'd0,
		ST_FULL  = 3'd1,
		ST_DISP  = 3'd2,
		ST_EMPTY = 3'd3,
		ST_DECAY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ENQ,
		RES_EMPTY,
		RES_DISP,
		RES_DECAY
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DISP,
		S_WALK
	} state_t;

	typedef struct packed {
		logic latch;
		logic enq;
		logic pop;
		logic walk_rd;
		logic walk_wr;
		res_t res;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  any_ready;
		logic  walk_end;
	} dp_status_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(CLASS_DEPTH - 1))
			nxt = '0;
		else
			nxt = ptr + 1'b1;
		return nxt;
	endfunction

endpackage

[rtl/mlqs_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module mlqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/mlqs_ctrl.sv]
// Sequencer that steps each operation through the datapath.
module mlqs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mlqs_pkg::dp_status_t stat,
	output mlqs_pkg::dp_cmd_t    cmd,
	output logic                 busy
);

	import mlqs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res     = RES_NONE;
		busy        = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.func)
					FUNC_ENQ: begin
						cmd.enq = 1'b1;
						cmd.res = RES_ENQ;
						state_d = S_IDLE;
					end
					FUNC_DISP: begin
						if (stat.any_ready) begin
							cmd.pop = 1'b1;
							state_d = S_DISP;
						end else begin
							cmd.res = RES_EMPTY;
							state_d = S_IDLE;
						end
					end
					FUNC_DECAY: begin
						cmd.walk_rd = 1'b1;
						state_d     = S_WALK;
					end
					FUNC_NOP: begin
						cmd.res = RES_DECAY;
						state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DISP: begin
				cmd.res = RES_DISP;
				state_d = S_IDLE;
			end
			S_WALK: begin
				cmd.walk_wr = 1'b1;
				if (stat.walk_end) begin
					cmd.res = RES_DECAY;
					state_d = S_IDLE;
				end else begin
					cmd.walk_rd = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/mlqs_dp.sv]
// Queue pointers, counts, entry RAM and result registers.
module mlqs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlqs_pkg::dp_cmd_t             cmd,
	output mlqs_pkg::dp_status_t          stat,
	input  logic [mlqs_pkg::FUNC_W-1:0]   func,
	input  logic [mlqs_pkg::ID_W-1:0]     task_id,
	input  logic [mlqs_pkg::PRIO_W-1:0]   prio,
	input  logic [mlqs_pkg::CPU_W-1:0]    cpu_use,
	output logic                          done,
	output logic [mlqs_pkg::STAT_W-1:0]   status,
	output logic [mlqs_pkg::ID_W-1:0]     out_id,
	output logic [mlqs_pkg::PRIO_W-1:0]   out_prio,
	output logic [mlqs_pkg::CPU_W-1:0]    out_cpu
);

	import mlqs_pkg::*;

	// latched command beat
	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CPU_W-1:0]  cpu_q;

	// per-class queue state
	logic [PTR_W-1:0] head_q [NUM_CLASSES];
	logic [PTR_W-1:0] tail_q [NUM_CLASSES];
	logic [CNT_W-1:0] count_q [NUM_CLASSES];

	// decay sweep
	logic [ADDR_W-1:0] walk_q;
	logic [ADDR_W-1:0] wr_addr_q;

	// result registers
	logic              done_q;
	status_t           status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic [CPU_W-1:0]  out_cpu_q;

	logic [PRIO_W-1:0]  cls_raw;
	logic [CLS_W-1:0]   enq_cls;
	logic               full;
	logic [CLS_W-1:0]   pop_cls;
	logic               any_ready;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [ENTRY_W-1:0] halved;
	logic               enq_ok;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			id_q   <= task_id;
			prio_q <= prio;
			cpu_q  <= cpu_use;
		end
	end

	// class of the task being enqueued, saturated to the last class
	always_comb begin
		cls_raw = PRIO_W'(prio_q / PRIO_PER_CLASS);
		if (cls_raw > PRIO_W'(NUM_CLASSES - 1))
			enq_cls = CLS_W'(NUM_CLASSES - 1);
		else
			enq_cls = CLS_W'(cls_raw);
	end

	assign full   = (count_q[enq_cls] == CNT_W'(CLASS_DEPTH));
	assign enq_ok = cmd.enq && !full;

	// lowest non-empty class
	always_comb begin
		pop_cls   = '0;
		any_ready = 1'b0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (count_q[c] != '0) begin
				pop_cls   = CLS_W'(c);
				any_ready = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else if (enq_ok) begin
			tail_q[enq_cls]  <= ptr_inc(tail_q[enq_cls]);
			count_q[enq_cls] <= count_q[enq_cls] + 1'b1;
		end else if (cmd.pop) begin
			head_q[pop_cls]  <= ptr_inc(head_q[pop_cls]);
			count_q[pop_cls] <= count_q[pop_cls] - 1'b1;
		end
	end

	// sweep counter wraps back to zero after the last address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q    <= '0;
			wr_addr_q <= '0;
		end else if (cmd.walk_rd) begin
			walk_q    <= walk_q + 1'b1;
			wr_addr_q <= walk_q;
		end
	end

	// id 1 keeps its usage
	always_comb begin
		halved = ram_rdata;
		if (ram_rdata[ENTRY_W-1 -: ID_W] != ID_W'(1))
			halved[CPU_W-1:0] = {1'b0, ram_rdata[CPU_W-1:1]};
	end

	assign ram_we    = enq_ok || cmd.walk_wr;
	assign ram_waddr = cmd.walk_wr ? wr_addr_q : {enq_cls, tail_q[enq_cls]};
	assign ram_wdata = cmd.walk_wr ? halved : {id_q, prio_q, cpu_q};
	assign ram_raddr = cmd.walk_rd ? walk_q : {pop_cls, head_q[pop_cls]};

	mlqs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (cmd.res != RES_NONE);
	end

	always_ff @(posedge clk) begin
		if (cmd.res != RES_NONE) begin
			out_id_q   <= '0;
			out_prio_q <= '0;
			out_cpu_q  <= '0;
			case (cmd.res)
				RES_ENQ:   status_q <= full ? ST_FULL : ST_ENQ;
				RES_EMPTY: status_q <= ST_EMPTY;
				RES_DISP: begin
					status_q   <= ST_DISP;
					out_id_q   <= ram_rdata[ENTRY_W-1 -: ID_W];
					out_prio_q <= ram_rdata[CPU_W +: PRIO_W];
					out_cpu_q  <= ram_rdata[CPU_W-1:0];
				end
				default:   status_q <= ST_DECAY;
			endcase
		end
	end

	assign stat.func      = func_t'(func_q);
	assign stat.any_ready = any_ready;
	assign stat.walk_end  = (walk_q == '0);

	assign done     = done_q;
	assign status   = status_q;
	assign out_id   = out_id_q;
	assign out_prio = out_prio_q;
	assign out_cpu  = out_cpu_q;

endmodule

[rtl/multilevel_priority_queue_scheduler_top.sv]
// Top level of the multilevel priority queue scheduler.
//
//  channel   handshake        beat fields
//  --------  ---------------  ------------------------------------
//  command   start & !busy    func, task_id, prio, cpu_use
//  result    done (1 cycle)   status, out_id, out_prio, out_cpu
//
// Steps: enqueue and the reserved no-op go from the execute state to the
// result register; dispatch adds a state for one registered read of the
// entry RAM. Decay sweeps the whole entry RAM, one read-modify-write per
// cycle overlapped, before its result is registered.
// busy stays high from the accept edge until the result cycle; the next
// command beat can be taken in the cycle that shows the result.
// Reset (arst_n low) empties all queues at once; no clearing pass.
// The result beat cannot be stalled: done is high for exactly one cycle.
module multilevel_priority_queue_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mlqs_pkg::FUNC_W-1:0]   func,
	input  logic [mlqs_pkg::ID_W-1:0]     task_id,
	input  logic [mlqs_pkg::PRIO_W-1:0]   prio,
	input  logic [mlqs_pkg::CPU_W-1:0]    cpu_use,
	output logic                          done,
	output logic [mlqs_pkg::STAT_W-1:0]   status,
	output logic [mlqs_pkg::ID_W-1:0]     out_id,
	output logic [mlqs_pkg::PRIO_W-1:0]   out_prio,
	output logic [mlqs_pkg::CPU_W-1:0]    out_cpu
);

	import mlqs_pkg::*;

	// controller <-> datapath
	dp_cmd_t    cmd;
	dp_status_t stat;

	// sequencer: idle -> exec -> (dispatch read | decay sweep) -> idle
	mlqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// queue state, entry RAM and the result register
	mlqs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.func     (func),
		.task_id  (task_id),
		.prio     (prio),
		.cpu_use  (cpu_use),
		.done     (done),
		.status   (status),
		.out_id   (out_id),
		.out_prio (out_prio),
		.out_cpu  (out_cpu)
	);

endmodule

[rtl/mlqs_checker.sv]
// Port-level checks for the scheduler top level, with its bind.
`include "assert_macros.svh"

module mlqs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [mlqs_pkg::STAT_W-1:0]   status,
	input logic [mlqs_pkg::ID_W-1:0]     out_id,
	input logic [mlqs_pkg::PRIO_W-1:0]   out_prio,
	input logic [mlqs_pkg::CPU_W-1:0]    out_cpu
);

	import mlqs_pkg::*;

	// an accepted beat keeps the block busy in the next cycle
	`MLQS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// a result only closes work that was in flight
	`MLQS_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy))

	// one result per command: never two in a row
	`MLQS_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)

	// only a dispatch carries a task
	`MLQS_ASSERT_IMP(a_zero_fields, clk, arst_n, done && (status != ST_DISP),
		(out_id == '0) && (out_prio == '0) && (out_cpu == '0))

	// a result beat carries one of the defined status codes
	`MLQS_ASSERT_IMP(a_status_code, clk, arst_n, done,
		(status == ST_ENQ) || (status == ST_FULL) || (status == ST_DISP) ||
		(status == ST_EMPTY) || (status == ST_DECAY))

endmodule

bind multilevel_priority_queue_scheduler_top mlqs_checker u_mlqs_checker (.*);
